FILE: rtl/core/u8u16_pkg.sv
// Shared types, constants and helper functions for the UTF-8 to UTF-16 transcoder.
// Used by the controller, the datapath and the top level; depends on nothing else.
package u8u16_pkg;

	// Depth of the store that keeps the lead byte and its continuation bytes.
	localparam int MAX_HELD_BYTES = 7;
	localparam int HELD_IDX_W     = $clog2(MAX_HELD_BYTES);
	localparam int CNT_W          = $clog2(MAX_HELD_BYTES + 1);

	localparam logic [7:0]  LEAD_MIN      = 8'hC0;
	localparam logic [15:0] REPLACEMENT   = 16'hFFFD;
	localparam logic [31:0] SURR_LO       = 32'h0000_D800;
	localparam logic [31:0] SURR_HI       = 32'h0000_DFFF;
	localparam logic [31:0] BMP_LIMIT     = 32'h0001_0000;
	localparam logic [31:0] UNICODE_MAX   = 32'h0010_FFFF;
	localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_FLUSH,
		ST_START,
		ST_ENC,
		ST_ENC_LO
	} u8u16_state_t;

	typedef enum logic [1:0] {
		SEL_HELD,
		SEL_BYTE,
		SEL_ENC_FIRST,
		SEL_ENC_LO
	} u8u16_sel_t;

	typedef struct packed {
		logic       capture;
		logic       accum;
		logic       open_seq;
		logic       flush_next;
		logic       seq_clear;
		logic       emit;
		u8u16_sel_t emit_sel;
		logic       emit_last;
	} u8u16_cmd_t;

	typedef struct packed {
		logic open;
		logic cont;
		logic exp_one;
		logic byte_emit;
		logic last;
		logic flush_end;
		logic enc_pair;
		logic slot_free;
	} u8u16_status_t;

	// Sequence length of a lead byte: its count of leading ones, capped at 7.
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		if (b[5] == 1'b0) begin
			len = 3'd2;
		end else if (b[4] == 1'b0) begin
			len = 3'd3;
		end else if (b[3] == 1'b0) begin
			len = 3'd4;
		end else if (b[2] == 1'b0) begin
			len = 3'd5;
		end else if (b[1] == 1'b0) begin
			len = 3'd6;
		end else begin
			len = 3'd7;
		end
		return len;
	endfunction

	// Payload bits that a lead byte of the given length carries.
	function automatic logic [7:0] lead_payload(input logic [7:0] b, input logic [2:0] len);
		logic [7:0] p;
		if (len >= 3'd7) begin
			p = 8'd0;
		end else begin
			p = b & (8'hFF >> (len + 3'd1));
		end
		return p;
	endfunction

endpackage

FILE: rtl/core/u8u16_ctrl.sv
// Sequencing state machine of the UTF-8 to UTF-16 transcoder.
// Depends on u8u16_pkg; drives the datapath through u8u16_cmd_t.
module u8u16_ctrl
	import u8u16_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  u8u16_status_t status,
	output u8u16_cmd_t    cmd
);

	u8u16_state_t state_q, state_nx;
	logic         start_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			start_pend_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_DISPATCH) begin
				start_pend_q <= status.open && !status.cont;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (status.open && status.cont) begin
					if (status.exp_one) begin
						state_nx = ST_ENC;
					end else if (status.last) begin
						state_nx = ST_FLUSH;
					end else begin
						state_nx = ST_IDLE;
					end
				end else if (status.open) begin
					state_nx = ST_FLUSH;
				end else begin
					state_nx = ST_START;
				end
			end
			ST_FLUSH: begin
				if (status.slot_free && status.flush_end) begin
					state_nx = start_pend_q ? ST_START : ST_IDLE;
				end
			end
			ST_START: begin
				if (!status.byte_emit || status.slot_free) begin
					state_nx = ST_IDLE;
				end
			end
			ST_ENC: begin
				if (status.slot_free) begin
					state_nx = status.enc_pair ? ST_ENC_LO : ST_IDLE;
				end
			end
			ST_ENC_LO: begin
				if (status.slot_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DISPATCH: begin
				cmd.accum = status.open && status.cont;
			end
			ST_FLUSH: begin
				if (status.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = SEL_HELD;
					cmd.emit_last = status.last && status.flush_end && !start_pend_q;
					cmd.seq_clear = status.flush_end;
					cmd.flush_next = !status.flush_end;
				end
			end
			ST_START: begin
				if (!status.byte_emit) begin
					cmd.open_seq = 1'b1;
				end else if (status.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = SEL_BYTE;
					cmd.emit_last = status.last;
				end
			end
			ST_ENC: begin
				if (status.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = SEL_ENC_FIRST;
					cmd.emit_last = status.last && !status.enc_pair;
					cmd.seq_clear = !status.enc_pair;
				end
			end
			ST_ENC_LO: begin
				if (status.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = SEL_ENC_LO;
					cmd.emit_last = status.last;
					cmd.seq_clear = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: rtl/core/u8u16_dp.sv
// Datapath of the UTF-8 to UTF-16 transcoder: input register, sequence state,
// held-byte store, surrogate encoder and output register. Depends on u8u16_pkg.
module u8u16_dp
	import u8u16_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    in_byte,
	input  logic          last_byte,
	input  u8u16_cmd_t    cmd,
	output u8u16_status_t status,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [15:0]   code_unit,
	output logic          last_unit
);

	logic [7:0]       byte_q;
	logic             last_q;
	logic [31:0]      acc_q;
	logic [2:0]       exp_q;
	logic [CNT_W-1:0] gcnt_q;
	logic [CNT_W-1:0] fidx_q;
	logic [7:0]       held_q [MAX_HELD_BYTES];
	logic             out_valid_q;
	logic [15:0]      code_unit_q;
	logic             last_unit_q;

	logic [2:0]  len;
	logic        bad_val;
	logic        small_val;
	logic [20:0] diff;
	logic [15:0] enc_first;
	logic [15:0] enc_lo;
	logic [15:0] unit_nx;
	logic        slot_free;
	logic        hold_cont;

	assign len       = lead_len(byte_q);
	assign slot_free = !out_valid_q || out_ready;

	// Value check and surrogate split of the completed code point.
	assign bad_val   = ((acc_q >= SURR_LO) && (acc_q <= SURR_HI)) || (acc_q > UNICODE_MAX);
	assign small_val = acc_q < BMP_LIMIT;
	assign diff      = acc_q[20:0] - BMP_LIMIT[20:0];
	assign enc_lo    = LO_SURR_BASE | {6'd0, diff[9:0]};
	always_comb begin
		if (bad_val) begin
			enc_first = REPLACEMENT;
		end else if (small_val) begin
			enc_first = acc_q[15:0];
		end else begin
			enc_first = HI_SURR_BASE | {6'd0, diff[19:10]};
		end
	end

	always_comb begin
		case (cmd.emit_sel)
			SEL_HELD:      unit_nx = {8'd0, held_q[fidx_q[HELD_IDX_W-1:0]]};
			SEL_BYTE:      unit_nx = {8'd0, byte_q};
			SEL_ENC_FIRST: unit_nx = enc_first;
			SEL_ENC_LO:    unit_nx = enc_lo;
			default:       unit_nx = REPLACEMENT;
		endcase
	end

	assign status.open      = exp_q != 3'd0;
	assign status.cont      = byte_q[7:6] == 2'b10;
	assign status.exp_one   = exp_q == 3'd1;
	assign status.byte_emit = (byte_q < LEAD_MIN) || last_q || (len > 3'(MAX_HELD_BYTES));
	assign status.last      = last_q;
	assign status.flush_end = fidx_q == (gcnt_q - CNT_W'(1));
	assign status.enc_pair  = !bad_val && !small_val;
	assign status.slot_free = slot_free;

	// A continuation byte is kept for a possible flush unless it completes the sequence.
	assign hold_cont = cmd.accum && (exp_q != 3'd1) && (gcnt_q < CNT_W'(MAX_HELD_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			exp_q  <= '0;
			gcnt_q <= '0;
			fidx_q <= '0;
		end else begin
			if (cmd.accum) begin
				acc_q <= {acc_q[25:0], byte_q[5:0]};
				exp_q <= exp_q - 3'd1;
				if (hold_cont) begin
					gcnt_q <= gcnt_q + CNT_W'(1);
				end
			end else if (cmd.open_seq) begin
				acc_q  <= {24'd0, lead_payload(byte_q, len)};
				exp_q  <= len - 3'd1;
				gcnt_q <= CNT_W'(1);
			end else if (cmd.seq_clear) begin
				acc_q  <= '0;
				exp_q  <= '0;
				gcnt_q <= '0;
				fidx_q <= '0;
			end else if (cmd.flush_next) begin
				fidx_q <= fidx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q <= in_byte;
			last_q <= last_byte;
		end
		if (hold_cont) begin
			held_q[gcnt_q[HELD_IDX_W-1:0]] <= byte_q;
		end else if (cmd.open_seq) begin
			held_q[0] <= byte_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			code_unit_q <= unit_nx;
			last_unit_q <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign code_unit = code_unit_q;
	assign last_unit = last_unit_q;

endmodule

FILE: rtl/core/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder.
// Instantiates u8u16_ctrl and u8u16_dp; types and constants come from u8u16_pkg.

// The block takes one UTF-8 byte per item, with last_byte marking the end of the
// stream, and returns UTF-16 code units on a valid/ready output channel. A lead
// byte (0xC0 or above) opens a sequence of length = leading ones, capped at 7;
// each continuation byte adds six payload bits. A completed sequence yields one
// unit, or a high and then a low surrogate; values in the surrogate range or above
// U+10FFFF yield U+FFFD, and overlong forms are passed as decoded. When a sequence
// is broken by a non-continuation byte, or the stream ends inside it, the lead byte
// and the continuation bytes gathered so far each come out as a Latin-1 code point,
// and the breaking byte is then handled afresh. last_unit is set on the final unit
// produced by a last-marked byte. Items are handled one at a time by a controller
// that steps the datapath: an item is accepted only in the idle state, and the
// dispatch state follows each accept. An ASCII or stray byte then goes through the
// start state, an extending continuation byte back to idle, a completing byte the
// encode and, for a pair, low-surrogate states; a flush emits one held byte per step.
// Each emitted unit needs a free output register; a stalled output channel holds
// the controller. That register lets a finished unit wait while the next is taken.
module utf8_to_utf16_transcoder
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        last_unit
);

	u8u16_cmd_t    cmd;
	u8u16_status_t status;

	// Controller: decides per cycle which datapath step runs.
	u8u16_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: holds the byte, the open sequence and the output register.
	u8u16_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.code_unit (code_unit),
		.last_unit (last_unit)
	);

endmodule
